// ===== hdl/sks_pkg.sv =====
`default_nettype none

package sks_pkg;

    // Width of the error, noise and measurement registers
    localparam int ERR_BITS = 32;

    // Configuration port
    localparam int ADDR_BITS = 4;
    localparam int REG_IDX_BITS = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_MEAS_ERR  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_INIT_ERR  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PROC_NOISE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_STEP,
        S_STEP,
        S_ERR,
        S_NOISE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/scalar_kalman_smoother.sv =====
`default_nettype none

// A sample is accepted only while idle; the next one is taken after the result is loaded.
// Each sample passes through the bit-serial gain divider
// followed by three passes through one shared multiplier.
// Reset (synchronous, active low): estimate 0, error and registers to their reset values,
// no result pending.
module scalar_kalman_smoother
    import sks_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Sample input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]          i_sample,
    // Result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] o_estimate_fixed,
    output logic [SAMPLE_BITS-1:0]               o_estimate_whole,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ADDR_BITS-1:0]            paddr,
    input  wire logic [ERR_BITS-1:0]             pwdata,
    output logic [ERR_BITS-1:0]                  prdata,
    output logic                                 pready
);

    localparam int F        = FRACTION_BITS;
    localparam int EST_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int AW       = (EST_BITS > ERR_BITS) ? EST_BITS : ERR_BITS;
    localparam int PW       = AW + ERR_BITS;
    localparam int GW       = FRACTION_BITS + 1;

    localparam logic [ERR_BITS-1:0] RST_MEAS  = ERR_BITS'(64'd10 << FRACTION_BITS);
    localparam logic [ERR_BITS-1:0] RST_INIT  = ERR_BITS'(64'd1 << FRACTION_BITS);
    localparam logic [ERR_BITS-1:0] RST_NOISE =
        ERR_BITS'(((64'd5 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [GW-1:0]       GAIN_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};

    t_state r_state, n_state;

    logic [ERR_BITS-1:0] r_meas, r_init, r_noise;
    logic [EST_BITS-1:0] r_estimate;
    logic [ERR_BITS-1:0] r_error;
    logic                r_up;
    logic                r_div_zero;
    logic [EST_BITS-1:0] r_mag;
    logic [GW-1:0]       r_gain;
    logic [EST_BITS-1:0] r_step;
    logic [ERR_BITS-1:0] r_err_part;
    logic [PW-1:0]       r_prod;
    logic                r_out_valid;
    logic [EST_BITS-1:0] r_out_fixed;

    logic                in_ready;
    logic                div_start;
    logic                out_load;
    logic                accept;
    logic                cfg_write;
    logic [REG_IDX_BITS-1:0] cfg_idx;
    logic [EST_BITS-1:0] target;
    logic                up;
    logic [ERR_BITS:0]   divisor;
    logic                div_done;
    logic [GW-1:0]       div_quo;
    logic [AW-1:0]       mul_a;
    logic [ERR_BITS-1:0] mul_b;
    logic [ERR_BITS-1:0] noise_term;
    logic [ERR_BITS:0]   err_sum;

    assign cfg_idx   = paddr[ADDR_BITS-1:ADDR_BITS-REG_IDX_BITS];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_MEAS_ERR:   prdata = r_meas;
            REG_INIT_ERR:   prdata = r_init;
            REG_PROC_NOISE: prdata = r_noise;
            default:        prdata = '0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DIV;
            S_DIV:      if (div_done) n_state = S_MUL_STEP;
            S_MUL_STEP: n_state = S_STEP;
            S_STEP:     n_state = S_ERR;
            S_ERR:      n_state = S_NOISE;
            S_NOISE:    n_state = S_DONE;
            S_DONE:     if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_DONE:  out_load = !r_out_valid || i_out_ready;
            default: begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign o_in_ready = in_ready;
    assign accept     = i_in_valid && in_ready;
    assign div_start  = accept;

    // Sample offset from the current estimate
    always_comb begin
        target  = {i_sample, {F{1'b0}}};
        up      = target >= r_estimate;
        divisor = {1'b0, r_error} + {1'b0, r_meas};
    end

    sks_divider #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_error),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MUL_STEP: begin
                mul_a = AW'(r_mag);
                mul_b = ERR_BITS'(r_gain);
            end
            S_STEP: begin
                mul_a = AW'(r_error);
                mul_b = ERR_BITS'(GAIN_ONE - r_gain);
            end
            S_ERR: begin
                mul_a = AW'(r_step);
                mul_b = r_noise;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturate the noise term and form the error sum
    always_comb begin
        noise_term = (|r_prod[PW-1:F+ERR_BITS]) ? '1 : r_prod[F +: ERR_BITS];
        err_sum    = {1'b0, r_err_part} + {1'b0, noise_term};
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (accept) begin
            r_up       <= up;
            r_mag      <= up ? (target - r_estimate) : (r_estimate - target);
            r_div_zero <= (divisor == '0);
        end
        if (r_state == S_DIV && div_done) begin
            r_gain <= r_div_zero ? '0 : div_quo;
        end
        if (r_state == S_STEP) begin
            r_step <= r_prod[F +: EST_BITS];
        end
        if (r_state == S_ERR) begin
            r_err_part <= r_prod[F +: ERR_BITS];
        end
        if (out_load) begin
            r_out_fixed <= r_estimate;
        end
    end

    // Filter state and configuration; register writes must arrive only while idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas      <= RST_MEAS;
            r_init      <= RST_INIT;
            r_noise     <= RST_NOISE;
            r_estimate  <= '0;
            r_error     <= RST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            // Move estimate toward the sample
            if (r_state == S_ERR) begin
                r_estimate <= r_up ? (r_estimate + r_step) : (r_estimate - r_step);
            end
            // Commit the new error, saturated
            if (r_state == S_NOISE) begin
                r_error <= err_sum[ERR_BITS] ? '1 : err_sum[ERR_BITS-1:0];
            end
            // Hold the result until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Register writes
            if (cfg_write) begin
                unique case (cfg_idx)
                    REG_MEAS_ERR:   r_meas <= pwdata;
                    REG_INIT_ERR: begin
                        r_init  <= pwdata;
                        r_error <= pwdata;
                    end
                    REG_PROC_NOISE: r_noise <= pwdata;
                    default:        r_meas <= r_meas;
                endcase
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_estimate_fixed = r_out_fixed;
    assign o_estimate_whole = r_out_fixed[EST_BITS-1:F];

endmodule

`default_nettype wire

// ===== hdl/sks_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Quotient = floor(dividend * 2^FRAC_BITS / divisor), valid when dividend <= divisor.
module sks_divider
    import sks_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [ERR_BITS-1:0]   i_dividend,
    input  wire logic [ERR_BITS:0]     i_divisor,
    output logic                       o_done,
    output logic [FRAC_BITS:0]         o_quotient
);

    localparam int CW = $clog2(FRAC_BITS + 2);
    localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [ERR_BITS+1:0]   r_rem;
    logic [ERR_BITS:0]     r_div;
    logic [FRAC_BITS-1:0]  r_quo;

    logic                  ge;
    logic [ERR_BITS+1:0]   trial;

    // Compare and conditionally subtract
    always_comb begin
        ge    = r_rem >= {1'b0, r_div};
        trial = ge ? (r_rem - {1'b0, r_div}) : r_rem;
    end

    assign o_done     = r_busy && (r_cnt == LAST);
    assign o_quotient = {r_quo, ge};

    // Control: run FRAC_BITS+1 steps after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: shift in one quotient bit, bring down a zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_dividend};
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[FRAC_BITS-2:0], ge};
            r_rem <= {trial[ERR_BITS:0], 1'b0};
        end
    end

endmodule

`default_nettype wire
